// ===== src/nstg_pkg.sv =====
// Shared types and constants for the note stepper tone generator.
// Holds the transaction structs, function codes and the note ROM contents.
// No dependencies.
package nstg_pkg;

    // Input transaction: function code and note number
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] note_code;
    } in_item_t;

    // Result transaction: line levels and status
    typedef struct packed {
        logic step_level;
        logic enable_n;
        logic playing;
        logic bad_note;
    } out_item_t;

    // Function codes carried in the func field
    typedef enum logic [1:0] {
        FUNC_TICK      = 2'd0,
        FUNC_NOTE      = 2'd1,
        FUNC_MALFORMED = 2'd2,
        FUNC_UNUSED    = 2'd3
    } func_t;

    localparam int          ROM_SIZE    = 88;
    localparam int          ROM_AW      = $clog2(ROM_SIZE);
    localparam logic [7:0]  FIRST_NOTE  = 8'd21;
    localparam logic [7:0]  STOP_CODE   = 8'hFF;
    localparam logic [7:0]  SCALE_RESET = 8'd40;
    localparam int          DUR_W       = 11;
    localparam int          PROD_W      = DUR_W + 8;

    // Half period per note, in 500 ns ticks
    localparam logic [15:0] HALF_ROM [ROM_SIZE] = '{
        16'd36360, 16'd34320, 16'd32400, 16'd30580, 16'd28860, 16'd27240, 16'd25710,
        16'd24270, 16'd22910, 16'd21260, 16'd20410, 16'd19260, 16'd18180, 16'd17160,
        16'd16200, 16'd15290, 16'd14290, 16'd13620, 16'd12860, 16'd12130, 16'd11450,
        16'd10810, 16'd10200, 16'd9631,  16'd9091,  16'd8581,  16'd8099,  16'd7645,
        16'd7216,  16'd6811,  16'd6428,  16'd6068,  16'd5727,  16'd5405,  16'd5102,
        16'd4816,  16'd4545,  16'd4290,  16'd4050,  16'd3822,  16'd3608,  16'd3405,
        16'd3214,  16'd3034,  16'd2863,  16'd2703,  16'd2551,  16'd2408,  16'd2273,
        16'd2145,  16'd2025,  16'd1910,  16'd1804,  16'd1703,  16'd1607,  16'd1517,
        16'd1432,  16'd1351,  16'd1276,  16'd1204,  16'd1136,  16'd1073,  16'd1012,
        16'd955,   16'd902,   16'd851,   16'd803,   16'd758,   16'd715,   16'd675,
        16'd637,   16'd602,   16'd568,   16'd536,   16'd506,   16'd477,   16'd451,
        16'd425,   16'd401,   16'd379,   16'd358,   16'd337,   16'd318,   16'd301,
        16'd284,   16'd268,   16'd253,   16'd238
    };

    // Note duration in toggles before scaling
    localparam logic [DUR_W-1:0] DUR_ROM [ROM_SIZE] = '{
        11'd7,   11'd7,   11'd8,   11'd8,   11'd9,   11'd9,   11'd10,  11'd10,
        11'd11,  11'd12,  11'd12,  11'd13,  11'd14,  11'd15,  11'd15,  11'd16,
        11'd17,  11'd18,  11'd19,  11'd21,  11'd22,  11'd23,  11'd25,  11'd26,
        11'd27,  11'd30,  11'd31,  11'd33,  11'd35,  11'd37,  11'd39,  11'd41,
        11'd44,  11'd46,  11'd49,  11'd52,  11'd55,  11'd58,  11'd62,  11'd65,
        11'd69,  11'd73,  11'd78,  11'd82,  11'd87,  11'd92,  11'd98,  11'd104,
        11'd110, 11'd117, 11'd123, 11'd131, 11'd139, 11'd147, 11'd156, 11'd165,
        11'd175, 11'd185, 11'd196, 11'd208, 11'd220, 11'd233, 11'd247, 11'd262,
        11'd277, 11'd294, 11'd311, 11'd330, 11'd349, 11'd370, 11'd392, 11'd415,
        11'd440, 11'd466, 11'd494, 11'd523, 11'd554, 11'd587, 11'd622, 11'd659,
        11'd698, 11'd740, 11'd786, 11'd831, 11'd880, 11'd932, 11'd988, 11'd1046
    };

endpackage

// ===== src/note_stepper_tone_generator_core.sv =====
// Top level of the note stepper tone generator.
// Holds the tone state, the note decode and the output skid stage.
// Depends on nstg_pkg.
//
// Usage:
//   The in channel (in_valid / in_stall / in_data) carries one transaction per
//   tick or note message; each accepted transaction produces exactly one result
//   on the out channel (out_valid / out_stall / out_data) with the step line,
//   enable line, running flag and bad-note flag after that transaction.
//   Results are registered. Throughput is one transaction per cycle while
//   in_stall is low; the per-item path is one ROM read plus one 11x8 multiply,
//   or one 16-bit increment and compare.
//   cfg_we / cfg_wdata write duration_scale; write it only while idle.
//   Reset (rst_n low, asynchronous) stops the tone, disables the motor, clears
//   the counters, sets the last note to the stop code and the scale to 40.
//   When the receiver stalls, the result holds in the output register and one
//   more transaction lands in the skid register; in_stall rises only while
//   the skid register is full.
module note_stepper_tone_generator_core
    import nstg_pkg::*;
#(
    parameter int NOTE_COUNT = 88
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam logic [7:0] NOTE_LIMIT = 8'(NOTE_COUNT);

    // Tone state
    logic [7:0]  scale_reg;
    logic [7:0]  last_note_reg,    last_note_next;
    logic        step_bit_reg,     step_bit_next;
    logic        enable_bar_reg,   enable_bar_next;
    logic        running_reg,      running_next;
    logic [15:0] hp_count_reg,     hp_count_next;
    logic [15:0] hp_len_reg,       hp_len_next;
    logic [15:0] toggle_count_reg, toggle_count_next;
    logic [15:0] toggle_limit_reg, toggle_limit_next;
    logic        bad_next;

    // Output and skid stage
    logic      out_valid_reg,  out_valid_next;
    out_item_t out_data_reg,   out_data_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t skid_data_reg,  skid_data_next;

    logic      in_fire;
    logic      out_fire;
    out_item_t result;

    // Note decode
    logic [7:0]        note_idx;
    logic [ROM_AW-1:0] rom_idx;
    logic              note_ok;
    logic [PROD_W-1:0] product;
    logic [15:0]       limit_sat;
    logic [15:0]       hp_inc;
    logic [15:0]       toggle_inc;

    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    assign note_idx = in_data.note_code - FIRST_NOTE;
    assign rom_idx  = note_idx[ROM_AW-1:0];
    assign note_ok  = (in_data.note_code >= FIRST_NOTE) && (note_idx < NOTE_LIMIT)
                      && (note_idx < 8'(ROM_SIZE));

    // Scale the duration and saturate to 16 bits
    assign product   = PROD_W'(DUR_ROM[rom_idx]) * PROD_W'(scale_reg);
    assign limit_sat = (product[PROD_W-1:16] != '0) ? 16'hFFFF : product[15:0];

    assign hp_inc     = hp_count_reg + 16'd1;
    assign toggle_inc = toggle_count_reg + 16'd1;

    // Advance the tone state for one transaction
    always_comb
    begin
        last_note_next    = last_note_reg;
        step_bit_next     = step_bit_reg;
        enable_bar_next   = enable_bar_reg;
        running_next      = running_reg;
        hp_count_next     = hp_count_reg;
        hp_len_next       = hp_len_reg;
        toggle_count_next = toggle_count_reg;
        toggle_limit_next = toggle_limit_reg;
        bad_next          = 1'b0;
        unique case (func_t'(in_data.func))
            FUNC_TICK:
            begin
                if (running_reg)
                begin
                    if (hp_inc < hp_len_reg)
                    begin
                        hp_count_next = hp_inc;
                    end
                    else
                    begin
                        hp_count_next     = '0;
                        step_bit_next     = !step_bit_reg;
                        toggle_count_next = toggle_inc;
                        if (toggle_inc == toggle_limit_reg)
                        begin
                            running_next    = 1'b0;
                            enable_bar_next = 1'b1;
                        end
                    end
                end
            end
            FUNC_NOTE:
            begin
                toggle_count_next = '0;
                last_note_next    = in_data.note_code;
                if (in_data.note_code != last_note_reg)
                begin
                    running_next    = 1'b0;
                    enable_bar_next = 1'b1;
                end
                if (in_data.note_code == STOP_CODE)
                begin
                    running_next    = 1'b0;
                    enable_bar_next = 1'b1;
                end
                else if (!note_ok)
                begin
                    running_next    = 1'b0;
                    enable_bar_next = 1'b1;
                    bad_next        = 1'b1;
                end
                else
                begin
                    toggle_limit_next = limit_sat;
                    hp_len_next       = HALF_ROM[rom_idx];
                    hp_count_next     = '0;
                    enable_bar_next   = 1'b0;
                    running_next      = 1'b1;
                end
            end
            FUNC_MALFORMED, FUNC_UNUSED:
            begin
                // drop: no effect
            end
            default:
            begin
            end
        endcase
    end

    assign result.step_level = step_bit_next;
    assign result.enable_n   = enable_bar_next;
    assign result.playing    = running_next;
    assign result.bad_note   = bad_next;

    // Route the result into the output register or the skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            scale_reg <= cfg_wdata;
        end
    end

    // Update the tone state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_note_reg    <= STOP_CODE;
            step_bit_reg     <= 1'b0;
            enable_bar_reg   <= 1'b1;
            running_reg      <= 1'b0;
            hp_count_reg     <= '0;
            hp_len_reg       <= '0;
            toggle_count_reg <= '0;
            toggle_limit_reg <= '0;
        end
        else if (in_fire)
        begin
            last_note_reg    <= last_note_next;
            step_bit_reg     <= step_bit_next;
            enable_bar_reg   <= enable_bar_next;
            running_reg      <= running_next;
            hp_count_reg     <= hp_count_next;
            hp_len_reg       <= hp_len_next;
            toggle_count_reg <= toggle_count_next;
            toggle_limit_reg <= toggle_limit_next;
        end
    end

    // Hold the output valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold the output payloads
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the note stepper tone generator core.
// Predicts step/enable/playing/bad_note per transaction and checks every result.
// Depends on nstg_pkg and note_stepper_tone_generator_core.
module tb;
    import nstg_pkg::*;

    localparam int NOTES       = 88;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int REPORT_MAX  = 10;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_item_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;

    // Half period per note in ticks, and duration in toggles before scaling
    logic [15:0] half_ticks [NOTES] = '{
        16'd36360, 16'd34320, 16'd32400, 16'd30580, 16'd28860, 16'd27240, 16'd25710,
        16'd24270, 16'd22910, 16'd21260, 16'd20410, 16'd19260, 16'd18180, 16'd17160,
        16'd16200, 16'd15290, 16'd14290, 16'd13620, 16'd12860, 16'd12130, 16'd11450,
        16'd10810, 16'd10200, 16'd9631,  16'd9091,  16'd8581,  16'd8099,  16'd7645,
        16'd7216,  16'd6811,  16'd6428,  16'd6068,  16'd5727,  16'd5405,  16'd5102,
        16'd4816,  16'd4545,  16'd4290,  16'd4050,  16'd3822,  16'd3608,  16'd3405,
        16'd3214,  16'd3034,  16'd2863,  16'd2703,  16'd2551,  16'd2408,  16'd2273,
        16'd2145,  16'd2025,  16'd1910,  16'd1804,  16'd1703,  16'd1607,  16'd1517,
        16'd1432,  16'd1351,  16'd1276,  16'd1204,  16'd1136,  16'd1073,  16'd1012,
        16'd955,   16'd902,   16'd851,   16'd803,   16'd758,   16'd715,   16'd675,
        16'd637,   16'd602,   16'd568,   16'd536,   16'd506,   16'd477,   16'd451,
        16'd425,   16'd401,   16'd379,   16'd358,   16'd337,   16'd318,   16'd301,
        16'd284,   16'd268,   16'd253,   16'd238
    };

    logic [15:0] dur_toggles [NOTES] = '{
        16'd7,   16'd7,   16'd8,   16'd8,   16'd9,   16'd9,   16'd10,  16'd10,
        16'd11,  16'd12,  16'd12,  16'd13,  16'd14,  16'd15,  16'd15,  16'd16,
        16'd17,  16'd18,  16'd19,  16'd21,  16'd22,  16'd23,  16'd25,  16'd26,
        16'd27,  16'd30,  16'd31,  16'd33,  16'd35,  16'd37,  16'd39,  16'd41,
        16'd44,  16'd46,  16'd49,  16'd52,  16'd55,  16'd58,  16'd62,  16'd65,
        16'd69,  16'd73,  16'd78,  16'd82,  16'd87,  16'd92,  16'd98,  16'd104,
        16'd110, 16'd117, 16'd123, 16'd131, 16'd139, 16'd147, 16'd156, 16'd165,
        16'd175, 16'd185, 16'd196, 16'd208, 16'd220, 16'd233, 16'd247, 16'd262,
        16'd277, 16'd294, 16'd311, 16'd330, 16'd349, 16'd370, 16'd392, 16'd415,
        16'd440, 16'd466, 16'd494, 16'd523, 16'd554, 16'd587, 16'd622, 16'd659,
        16'd698, 16'd740, 16'd786, 16'd831, 16'd880, 16'd932, 16'd988, 16'd1046
    };

    // Predicted tone state and scale register
    logic [7:0]  tone_scale;
    logic [7:0]  tone_last;
    logic        tone_step;
    logic        tone_en_n;
    logic        tone_run;
    logic [15:0] tone_hp_cnt;
    logic [15:0] tone_hp_len;
    logic [15:0] tone_toggles;
    logic [15:0] tone_limit;

    out_item_t pending_levels [$];

    int max_gap        = 0;
    int max_stall      = 0;
    int stall_hold     = 0;
    int mismatches     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int scale_writes   = 0;
    int toggles_seen   = 0;
    int expiries_seen  = 0;
    int bad_codes_seen = 0;

    note_stepper_tone_generator_core #(
        .NOTE_COUNT(NOTES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Generate a 12 ns clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // End the run if it never drains
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, pending_levels.size());
        $display("FAIL note_stepper_tone_generator_core");
        $finish;
    end

    // Advance the predicted tone state by one transaction and return the line levels
    function automatic out_item_t next_line_levels(input in_item_t it);
        int          idx;
        int unsigned prod;
        out_item_t   res;
        res.bad_note = 1'b0;
        case (func_t'(it.func))
            FUNC_TICK:
            begin
                if (tone_run)
                begin
                    tone_hp_cnt = tone_hp_cnt + 16'd1;
                    if (tone_hp_cnt >= tone_hp_len)
                    begin
                        tone_hp_cnt  = 16'd0;
                        tone_step    = ~tone_step;
                        tone_toggles = tone_toggles + 16'd1;
                        toggles_seen++;
                        if (tone_toggles == tone_limit)
                        begin
                            tone_run  = 1'b0;
                            tone_en_n = 1'b1;
                            expiries_seen++;
                        end
                    end
                end
            end
            FUNC_NOTE:
            begin
                tone_toggles = 16'd0;
                // A different note first silences the current one
                if (it.note_code != tone_last)
                begin
                    tone_run  = 1'b0;
                    tone_en_n = 1'b1;
                    tone_last = it.note_code;
                end
                idx = int'(it.note_code) - int'(FIRST_NOTE);
                if (it.note_code == STOP_CODE)
                begin
                    tone_run  = 1'b0;
                    tone_en_n = 1'b1;
                end
                else if (idx < 0 || idx >= NOTES)
                begin
                    tone_run     = 1'b0;
                    tone_en_n    = 1'b1;
                    res.bad_note = 1'b1;
                    bad_codes_seen++;
                end
                else
                begin
                    // Saturate the scaled duration at 16 bits
                    prod        = int'(dur_toggles[idx]) * int'(tone_scale);
                    tone_limit  = (prod > 32'hFFFF) ? 16'hFFFF : prod[15:0];
                    tone_hp_len = half_ticks[idx];
                    tone_hp_cnt = 16'd0;
                    tone_en_n   = 1'b0;
                    tone_run    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.step_level = tone_step;
        res.enable_n   = tone_en_n;
        res.playing    = tone_run;
        return res;
    endfunction

    // Check each result transaction and draw the stall before the next one
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        logic      stall_next;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_levels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result %b with nothing pending", out_data);
            end
            else
            begin
                want = pending_levels.pop_front();
                results_seen++;
                if (out_data.step_level !== want.step_level ||
                    out_data.enable_n   !== want.enable_n   ||
                    out_data.playing    !== want.playing    ||
                    out_data.bad_note   !== want.bad_note)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"result %0d: expected step=%b en_n=%b play=%b bad=%b,",
                                  " got step=%b en_n=%b play=%b bad=%b"},
                                 results_seen, want.step_level, want.enable_n,
                                 want.playing, want.bad_note, out_data.step_level,
                                 out_data.enable_n, out_data.playing, out_data.bad_note);
                end
            end
            stall_hold = $urandom_range(0, max_stall);
        end
        if (stall_hold != 0)
        begin
            stall_next = 1'b1;
            stall_hold--;
        end
        else
            stall_next = 1'b0;
        out_stall <= stall_next;
    end

    // Send one input transaction after a random gap and record its prediction
    task automatic send_item(input func_t f, input logic [7:0] code);
        in_item_t it;
        int       gap;
        it.func      = f;
        it.note_code = code;
        gap          = $urandom_range(0, max_gap);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_levels.push_back(next_line_levels(it));
        items_sent++;
    endtask

    // Drop valid and hold until every pending result has arrived
    task automatic wait_idle;
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_scale(input logic [7:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        tone_scale  = value;
        scale_writes++;
    endtask

    // Decode of every code class, idle ticks and ignored function codes
    task automatic test_note_decode;
        max_gap   = 5;
        max_stall = 5;
        send_item(FUNC_NOTE, STOP_CODE);
        send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_MALFORMED, 8'h00);
        send_item(FUNC_UNUSED, 8'hFF);
        send_item(FUNC_NOTE, FIRST_NOTE);
        send_item(FUNC_TICK, 8'hFF);
        send_item(FUNC_NOTE, FIRST_NOTE);
        send_item(FUNC_MALFORMED, 8'hAA);
        send_item(FUNC_UNUSED, 8'h55);
        send_item(FUNC_NOTE, 8'd108);
        send_item(FUNC_TICK, 8'h5A);
        send_item(FUNC_NOTE, 8'd20);
        send_item(FUNC_NOTE, 8'd109);
        send_item(FUNC_NOTE, 8'd0);
        send_item(FUNC_NOTE, 8'd128);
        send_item(FUNC_NOTE, 8'd254);
        send_item(FUNC_NOTE, STOP_CODE);
        send_item(FUNC_NOTE, 8'd108);
        send_item(FUNC_NOTE, STOP_CODE);
        send_item(FUNC_NOTE, 8'd64);
        send_item(FUNC_TICK, 8'hA5);
        send_item(FUNC_NOTE, STOP_CODE);
        wait_idle();
    endtask

    // Step line flips every half period; retrigger and note change mid-period
    task automatic test_half_period;
        max_gap   = 5;
        max_stall = 5;
        send_item(FUNC_NOTE, 8'd108);
        repeat (240) send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_NOTE, 8'd108);
        repeat (60) send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_NOTE, 8'd107);
        repeat (60) send_item(FUNC_TICK, 8'h00);
        wait_idle();
    endtask

    // Play one tone at unit scale back to back, stop it, then tick while stopped
    task automatic test_stop_and_idle;
        write_scale(8'd1);
        max_gap   = 0;
        max_stall = 0;
        send_item(FUNC_NOTE, 8'd108);
        repeat (20) send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_NOTE, STOP_CODE);
        repeat (20) send_item(FUNC_TICK, 8'h00);
        wait_idle();
    endtask

    // Saturated limit at full scale, zero scale, then back to the reset value
    task automatic test_scale_extremes;
        write_scale(8'd255);
        max_gap   = 5;
        max_stall = 5;
        send_item(FUNC_NOTE, 8'd108);
        repeat (20) send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_NOTE, FIRST_NOTE);
        repeat (20) send_item(FUNC_TICK, 8'h00);
        write_scale(8'd0);
        send_item(FUNC_NOTE, 8'd104);
        repeat (310) send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_NOTE, STOP_CODE);
        write_scale(SCALE_RESET);
    endtask

    // Note messages followed by tick bursts, with noise and broken codes mixed in
    task automatic test_random_traffic;
        int         phase;
        int         mark;
        int         r;
        int         burst;
        logic [7:0] code;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       write_scale(8'($urandom_range(1, 255)));
                1:       write_scale(8'd1);
                2:       write_scale(8'd255);
                default: write_scale(8'($urandom_range(0, 255)));
            endcase
            mark = items_sent;
            while (items_sent - mark < 100)
            begin
                // Run some sequences back to back with no idling
                if ($urandom_range(0, 3) == 0)
                begin
                    max_gap   = 0;
                    max_stall = 0;
                end
                else
                begin
                    max_gap   = 5;
                    max_stall = 5;
                end
                r = $urandom_range(0, 99);
                if (r < 45)
                    code = 8'($urandom_range(100, 108));
                else if (r < 60)
                    code = tone_last;
                else if (r < 75)
                    code = 8'($urandom_range(21, 108));
                else if (r < 85)
                    code = STOP_CODE;
                else
                    code = 8'($urandom_range(0, 255));
                send_item(FUNC_NOTE, code);
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(230, 320)
                                                    : $urandom_range(0, 12);
                repeat (burst)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(func_t'(2'($urandom_range(2, 3))),
                                  8'($urandom_range(0, 255)));
                    else
                        send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
                end
            end
        end
        wait_idle();
    endtask

    initial
    begin
        // Hold reset, then start the predictor from its reset state
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tone_scale   = SCALE_RESET;
        tone_last    = STOP_CODE;
        tone_step    = 1'b0;
        tone_en_n    = 1'b1;
        tone_run     = 1'b0;
        tone_hp_cnt  = 16'd0;
        tone_hp_len  = 16'd0;
        tone_toggles = 16'd0;
        tone_limit   = 16'd0;

        test_note_decode();
        test_half_period();
        test_stop_and_idle();
        test_scale_extremes();
        test_random_traffic();
        wait_idle();

        $display("covered %0d transactions, %0d results checked, %0d scale writes",
                 items_sent, results_seen, scale_writes);
        $display({"tone activity: %0d step toggles, %0d tone expiries,",
                  " %0d bad codes, %0d mismatches"},
                 toggles_seen, expiries_seen, bad_codes_seen, mismatches);
        if (mismatches == 0)
            $display("PASS note_stepper_tone_generator_core");
        else
            $display("FAIL note_stepper_tone_generator_core");
        $finish;
    end

endmodule
